// ----- hw/rtl/diag_frame_deframer_assert.svh -----
// Assertion macros shared by the deframer RTL.
// Needs aclk and aresetn in the scope of each use.
`ifndef DIAG_FRAME_DEFRAMER_ASSERT_SVH
`define DIAG_FRAME_DEFRAMER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define DFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Condition that holds at every clock edge outside reset.
`define DFD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("deframer invariant failed");

`endif

// ----- hw/rtl/dfd_pkg.sv -----
// Shared constants and types of the diagnostic frame deframer.
// No dependencies.
`default_nettype none
package dfd_pkg;
    localparam logic [7:0] MAGIC_FIRST  = 8'h48;
    localparam logic [7:0] MAGIC_SECOND = 8'h52;
    localparam logic [7:0] HDR_VERSION  = 8'd1;
    localparam logic [7:0] HDR_LENGTH   = 8'd39;

    localparam int HDR_BYTES     = 4;
    localparam int PAYLOAD_BYTES = 39;
    localparam int FRAME_BYTES   = HDR_BYTES + PAYLOAD_BYTES;
    localparam int FILL_W        = 6;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } q_entry_t;
endpackage
`default_nettype wire

// ----- hw/rtl/dfd_front.sv -----
// Front end: tracks the frame position and forwards payload bytes.
// Depends on dfd_pkg.
`default_nettype none
module dfd_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             byte_valid,
    input  wire logic [7:0]       byte_data,
    output logic                  push,
    output dfd_pkg::q_entry_t     push_entry
);
    import dfd_pkg::*;

    `include "diag_frame_deframer_assert.svh"

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              ver_ok_reg, ver_ok_next;
    logic [FILL_W-1:0] hunt_fill;
    logic              in_payload;
    logic              last_byte;

    localparam logic [FILL_W-1:0] FILL_HDR   = FILL_W'(HDR_BYTES);
    localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(FRAME_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_FRAME = FILL_W'(FRAME_BYTES);

    always_comb begin
        hunt_fill   = (byte_data == MAGIC_FIRST) ? FILL_W'(1) : '0;
        in_payload  = (fill_reg >= FILL_HDR) && (fill_reg < FILL_FRAME);
        last_byte   = (fill_reg == FILL_LAST);
        fill_next   = fill_reg;
        ver_ok_next = ver_ok_reg;
        if (byte_valid) begin
            if (fill_reg == '0 || fill_reg >= FILL_FRAME) begin
                fill_next = hunt_fill;
            end else if (fill_reg == FILL_W'(1)) begin
                fill_next = (byte_data == MAGIC_SECOND) ? FILL_W'(2) : hunt_fill;
            end else if (fill_reg == FILL_W'(2)) begin
                ver_ok_next = (byte_data == HDR_VERSION);
                fill_next   = FILL_W'(3);
            end else if (fill_reg == FILL_W'(3)) begin
                fill_next = (ver_ok_reg && byte_data == HDR_LENGTH) ? FILL_HDR : hunt_fill;
            end else begin
                fill_next = last_byte ? '0 : fill_reg + FILL_W'(1);
            end
        end
    end

    assign push            = byte_valid && in_payload;
    assign push_entry.last = last_byte;
    assign push_entry.data = byte_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            ver_ok_reg <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            ver_ok_reg <= ver_ok_next;
        end
    end

    `DFD_ASSERT_ALWAYS(a_fill_range, fill_reg < FILL_FRAME)
    `DFD_ASSERT_IMP(a_last_wraps, push && push_entry.last, ##1 fill_reg == '0)
endmodule
`default_nettype wire

// ----- hw/rtl/dfd_queue.sv -----
// Short queue between the front end and the frame assembler.
// Depends on dfd_pkg.
`default_nettype none
module dfd_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire dfd_pkg::q_entry_t push_entry,
    output logic                   full,
    output logic                   q_valid,
    output dfd_pkg::q_entry_t      q_entry,
    input  wire logic              pop
);
    import dfd_pkg::*;

    `include "diag_frame_deframer_assert.svh"

    q_entry_t            slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    `DFD_ASSERT_ALWAYS(a_count_bound, count_reg <= Q_CNT_W'(Q_DEPTH))
    `DFD_ASSERT_IMP(a_no_overflow, push, !full)
    `DFD_ASSERT_IMP(a_no_underflow, pop, q_valid)
    `DFD_ASSERT_ALWAYS(a_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_PTR_W-1:0])
endmodule
`default_nettype wire

// ----- hw/rtl/dfd_back.sv -----
// Back end: shifts in payload bytes and holds the decoded frame for the receiver.
// Depends on dfd_pkg.
`default_nettype none
module dfd_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire dfd_pkg::q_entry_t             q_entry,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [dfd_pkg::PAYLOAD_W-1:0]      m_tdata
);
    import dfd_pkg::*;

    logic [PAYLOAD_W-1:0] payload_reg;
    logic [PAYLOAD_W-1:0] payload_next;
    logic [PAYLOAD_W-1:0] out_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free     = !out_valid_reg || m_tready;
    assign pop          = q_valid && (!q_entry.last || out_free);
    assign payload_next = {q_entry.data, payload_reg[PAYLOAD_W-1:8]};

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (pop && q_entry.last) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            payload_reg <= payload_next;
            if (q_entry.last) begin
                out_reg <= payload_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/diag_frame_deframer.sv -----
// Top level of the diagnostic frame deframer.
// Depends on dfd_pkg, dfd_front, dfd_queue and dfd_back.
//
// Usage:
//   The slave stream takes one received byte per request in s_tdata. The block
//   hunts for a 43-byte frame (0x48, 0x52, version 1, length 39, 39 payload
//   bytes) and puts one decoded frame on the master stream per complete frame.
//   Throughput: one byte per cycle while the queue has room; the front end classifies each
//   byte in the cycle it is accepted.
//   Output path: the last frame byte is written into the four-entry queue, then
//   popped and loaded with the assembled payload into the output register,
//   which raises m_tvalid; bytes still queued ahead of it are popped first.
//   m_tdata is the 39 payload bytes in arrival order, so every field comes out
//   little-endian with the first payload byte in bits 7:0.
//   Stall: a frame waits in the output register while m_tready is low. Bytes
//   keep flowing into the assembler; once the queue fills behind a stalled
//   final byte, s_tready drops until the receiver takes the frame.
//   Reset (aresetn low, synchronous): hunting restarts, the queue empties and
//   any pending frame is dropped. No clearing pass is needed.
`default_nettype none
module diag_frame_deframer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] sequence_number, [63:32] link_group, [95:64] queue_group,
    // [103:96] reconnect_status, [135:104] usb_drops, [167:136] bt_drops,
    // [199:168] attempt_total, [231:200] success_total, [263:232] failure_total,
    // [279:264] event_queue_group, [311:280] event_drops
    output logic [311:0]      m_tdata
);
    import dfd_pkg::*;

    logic     q_full;
    logic     push;
    q_entry_t push_entry;
    logic     q_valid;
    q_entry_t q_entry;
    logic     pop;
    logic     byte_valid;

    assign s_tready   = !q_full;
    assign byte_valid = s_tvalid && s_tready;

    dfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (s_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    dfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    dfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule
`default_nettype wire

// ----- dv/frame_decode_checker.sv -----
`timescale 1ns / 1ps
// Checker for diag_frame_deframer: follows the byte and frame streams, rebuilds each frame
// from the accepted bytes and compares every decoded field with the result the block delivers.
// Depends on dfd_pkg.
module frame_decode_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [311:0] m_tdata,
    output int           fail_count,
    output int           outstanding,
    output int           frames_expected,
    output int           frames_checked
);
    import dfd_pkg::*;

    // declared high field first so the layout matches m_tdata
    typedef struct packed {
        logic [31:0] event_drops;
        logic [15:0] event_queue_group;
        logic [31:0] failure_total;
        logic [31:0] success_total;
        logic [31:0] attempt_total;
        logic [31:0] bt_drops;
        logic [31:0] usb_drops;
        logic [7:0]  reconnect_status;
        logic [31:0] queue_group;
        logic [31:0] link_group;
        logic [31:0] sequence_number;
    } frame_fields_t;

    frame_fields_t pending_frames[$];
    logic [7:0]  frame_bytes [FRAME_BYTES];
    int          held;
    int          fails;
    int          decoded_n;
    int          compared_n;

    function automatic logic [31:0] le_word(input int p);
        return {frame_bytes[HDR_BYTES + p + 3], frame_bytes[HDR_BYTES + p + 2],
                frame_bytes[HDR_BYTES + p + 1], frame_bytes[HDR_BYTES + p]};
    endfunction

    function automatic frame_fields_t decode_frame();
        frame_fields_t f;
        f.sequence_number   = le_word(0);
        f.link_group        = le_word(4);
        f.queue_group       = le_word(8);
        f.reconnect_status  = frame_bytes[HDR_BYTES + 12];
        f.usb_drops         = le_word(13);
        f.bt_drops          = le_word(17);
        f.attempt_total     = le_word(21);
        f.success_total     = le_word(25);
        f.failure_total     = le_word(29);
        f.event_queue_group = {frame_bytes[HDR_BYTES + 34], frame_bytes[HDR_BYTES + 33]};
        f.event_drops       = le_word(35);
        return f;
    endfunction

    function automatic void hunt(input logic [7:0] b);
        if (b == MAGIC_FIRST) begin
            frame_bytes[0] = b;
            held = 1;
        end else begin
            held = 0;
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        if (held == 0 || held >= FRAME_BYTES) begin
            hunt(b);
        end else if (held == 1) begin
            if (b == MAGIC_SECOND) begin
                frame_bytes[1] = b;
                held = 2;
            end else begin
                hunt(b);
            end
        end else begin
            frame_bytes[held] = b;
            held++;
            if (held == HDR_BYTES) begin
                if (frame_bytes[2] != HDR_VERSION || frame_bytes[3] != HDR_LENGTH)
                    hunt(b);
            end else if (held == FRAME_BYTES) begin
                held = 0;
                pending_frames.push_back(decode_frame());
                decoded_n++;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    function automatic void compare_frame(input frame_fields_t want, input frame_fields_t got);
        check_field("sequence_number", want.sequence_number, got.sequence_number);
        check_field("link_group", want.link_group, got.link_group);
        check_field("queue_group", want.queue_group, got.queue_group);
        check_field("reconnect_status", 32'(want.reconnect_status),
                    32'(got.reconnect_status));
        check_field("usb_drops", want.usb_drops, got.usb_drops);
        check_field("bt_drops", want.bt_drops, got.bt_drops);
        check_field("attempt_total", want.attempt_total, got.attempt_total);
        check_field("success_total", want.success_total, got.success_total);
        check_field("failure_total", want.failure_total, got.failure_total);
        check_field("event_queue_group", 32'(want.event_queue_group),
                    32'(got.event_queue_group));
        check_field("event_drops", want.event_drops, got.event_drops);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            held = 0;
            pending_frames.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_frames.size() == 0) begin
                    $error("frame with no request behind it: 0x%0h", m_tdata);
                    fails++;
                end else begin
                    compare_frame(pending_frames.pop_front(), frame_fields_t'(m_tdata));
                    compared_n++;
                end
            end
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata);
        end
        fail_count      <= fails;
        outstanding     <= pending_frames.size();
        frames_expected <= decoded_n;
        frames_checked  <= compared_n;
    end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Top of the diag_frame_deframer bench: clock, reset, byte stimulus and result back-pressure.
// Prediction and comparison live in frame_decode_checker; depends on dfd_pkg.
module tb;
    import dfd_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE       = 8;
    localparam int RANDOM_BYTES = 1200;

    localparam int PAY_ZERO   = 0;
    localparam int PAY_ONES   = 1;
    localparam int PAY_MAGIC  = 2;
    localparam int PAY_RANDOM = 3;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [311:0] m_tdata;

    int fail_count;
    int outstanding;
    int frames_expected;
    int frames_checked;
    int bytes_sent = 0;
    int seq_count  = 0;
    bit tx_gaps    = 1'b1;

    diag_frame_deframer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    frame_decode_checker frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .frames_expected (frames_expected),
        .frames_checked  (frames_checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic send_byte(input logic [7:0] b);
        int n;
        n = tx_gaps ? $urandom_range(0, 8) : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] ver, input logic [7:0] len);
        send_byte(MAGIC_FIRST);
        send_byte(MAGIC_SECOND);
        send_byte(ver);
        send_byte(len);
    endtask

    task automatic send_payload(input int style, input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++) begin
            case (style)
                PAY_ZERO: b = 8'h00;
                PAY_ONES: b = 8'hFF;
                PAY_MAGIC: begin
                    case ($urandom_range(0, 3))
                        0: b = MAGIC_FIRST;
                        1: b = MAGIC_SECOND;
                        2: b = HDR_VERSION;
                        default: b = HDR_LENGTH;
                    endcase
                end
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b);
        end
    endtask

    // sender stops until every predicted frame has been delivered
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin : rx_side
        int  n;
        int  taken;
        bit  gaps;
        taken = 0;
        gaps  = 1'b1;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (taken % 8 == 0)
                gaps = $urandom_range(0, 3) != 0;
            n = gaps ? $urandom_range(0, 8) : 0;
            if (taken == 8 || taken == 30)
                n = HOLD_CYCLES;
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int         pick;
        bit         mid_drain;
        logic [7:0] ver;
        logic [7:0] len;
        mid_drain = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // hunting drops stray bytes, including a lone second magic
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(MAGIC_SECOND);
        // repeated first magic restarts, then a bad second byte drops
        send_byte(MAGIC_FIRST);
        send_byte(MAGIC_FIRST);
        send_byte(8'h13);
        // bad version with first magic in the fourth slot becomes a new frame
        send_header(8'h02, MAGIC_FIRST);
        send_byte(MAGIC_SECOND);
        send_byte(HDR_VERSION);
        send_byte(HDR_LENGTH);
        send_payload(PAY_ZERO, PAYLOAD_BYTES);
        // bad length, plain drop
        send_header(HDR_VERSION, 8'd38);
        // version byte equal to first magic, length bad
        send_header(MAGIC_FIRST, 8'h00);
        // bad length that is the first magic restarts
        send_header(HDR_VERSION, MAGIC_FIRST);
        send_byte(MAGIC_SECOND);
        send_byte(HDR_VERSION);
        send_byte(HDR_LENGTH);
        send_payload(PAY_ONES, PAYLOAD_BYTES);
        send_header(HDR_VERSION, HDR_LENGTH);
        send_payload(PAY_MAGIC, PAYLOAD_BYTES);
        send_header(HDR_VERSION, HDR_LENGTH);
        send_payload(PAY_RANDOM, PAYLOAD_BYTES);
        wait_idle();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            seq_count++;
            tx_gaps = $urandom_range(0, 2) != 0;
            pick    = $urandom_range(0, 99);
            if (pick < 70) begin
                send_header(HDR_VERSION, HDR_LENGTH);
                send_payload($urandom_range(0, 9) < 6 ? PAY_RANDOM : $urandom_range(0, 2),
                             PAYLOAD_BYTES);
            end else if (pick < 80) begin
                send_payload(PAY_RANDOM, $urandom_range(1, 10));
            end else if (pick < 92) begin
                ver = $urandom_range(0, 1) ? HDR_VERSION : 8'($urandom_range(0, 255));
                len = $urandom_range(0, 3) == 0 ? MAGIC_FIRST : 8'($urandom_range(0, 255));
                if (ver == HDR_VERSION && len == HDR_LENGTH)
                    len = MAGIC_FIRST;
                send_header(ver, len);
            end else begin
                // cut short; what follows lands in this frame's payload
                send_header(HDR_VERSION, HDR_LENGTH);
                send_payload(PAY_RANDOM, $urandom_range(0, PAYLOAD_BYTES - 1));
            end
            if (!mid_drain && bytes_sent > RANDOM_BYTES / 2) begin
                mid_drain = 1'b1;
                wait_idle();
            end
        end

        wait_idle();
        $display("Run summary: %0d random bytes in %0d sequences after the header cases,",
                 bytes_sent, seq_count);
        $display("  %0d of %0d decoded frames compared, with receiver hold-offs and drains",
                 frames_checked, frames_expected);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/dfd_pkg.sv
hw/rtl/dfd_front.sv
hw/rtl/dfd_queue.sv
hw/rtl/dfd_back.sv
hw/rtl/diag_frame_deframer.sv
dv/frame_decode_checker.sv
dv/tb.sv
